@@ hdl/minicomputer_12bit_cpu_core_top_defines.svh @@
// assertion macros for the top-level core file
`ifndef MINICOMPUTER_12BIT_CPU_CORE_TOP_DEFINES_SVH
`define MINICOMPUTER_12BIT_CPU_CORE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MC12_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mc12 same-cycle check failed");
`define MC12_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mc12 next-cycle check failed");
`else
`define MC12_ASSERT_IMPL(name, ante, cons)
`define MC12_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ hdl/mc12_pkg.sv @@
package mc12_pkg;

	localparam int MAX_FIELDS = 8;
	localparam int FW = 3;
	localparam int WW = 12;
	localparam int MEM_AW = FW + WW;
	localparam int MEM_DEPTH = MAX_FIELDS * 4096;

	// item actions
	localparam logic [3:0] ACT_CYCLE      = 4'd0;
	localparam logic [3:0] ACT_LOAD_ADDR  = 4'd1;
	localparam logic [3:0] ACT_DEPOSIT    = 4'd2;
	localparam logic [3:0] ACT_EXAMINE    = 4'd3;
	localparam logic [3:0] ACT_CONTINUE   = 4'd4;
	localparam logic [3:0] ACT_START      = 4'd5;
	localparam logic [3:0] ACT_STOP       = 4'd6;
	localparam logic [3:0] ACT_KEY        = 4'd7;
	localparam logic [3:0] ACT_PRINT_DONE = 4'd8;

	// major opcodes
	localparam logic [2:0] OP_AND = 3'd0;
	localparam logic [2:0] OP_TAD = 3'd1;
	localparam logic [2:0] OP_ISZ = 3'd2;
	localparam logic [2:0] OP_DCA = 3'd3;
	localparam logic [2:0] OP_JMS = 3'd4;
	localparam logic [2:0] OP_JMP = 3'd5;
	localparam logic [2:0] OP_IOT = 3'd6;
	localparam logic [2:0] OP_OPR = 3'd7;

	localparam logic [11:0] JMP_MASK     = 12'o7400;
	localparam logic [11:0] JMP_CODE     = 12'o5000;
	localparam logic [11:0] OFFSET_MASK  = 12'o0177;
	localparam logic [11:0] PAGE_MASK    = 12'o7600;
	localparam logic [11:0] AUTOINC_MASK = 12'o7770;
	localparam logic [11:0] AUTOINC_BASE = 12'o0010;

	typedef enum logic [1:0] {ST_NONE, ST_FETCH, ST_DEFER, ST_EXEC} major_t;

	typedef struct packed {
		logic [3:0]  action;
		logic [11:0] switch_register;
		logic [2:0]  inst_field_switch;
		logic [2:0]  data_field_switch;
		logic        single_step_switch;
		logic [7:0]  key_char;
	} item_t;

	typedef struct packed {
		logic [1:0]  major_state;
		logic [11:0] program_counter;
		logic [11:0] accumulator;
		logic        link_bit;
		logic [11:0] memory_address;
		logic [11:0] memory_buffer;
		logic [2:0]  memory_field;
		logic [2:0]  instruction_field;
		logic        interrupt_on;
		logic        running;
		logic        print_valid;
		logic [7:0]  print_char;
	} out_item_t;

	typedef struct packed {
		logic [11:0] pc;
		logic [11:0] ac;
		logic        link;
		logic [11:0] mar;
		logic [11:0] mbr;
		logic [2:0]  access_field;
		logic [2:0]  opcode_top;
		major_t      cycle_state;
		logic        ion;
		logic        ion_delay;
		logic        run_flag;
		logic [2:0]  ifield;
		logic [2:0]  dfield;
		logic [2:0]  ifa;
		logic [2:0]  saved_d;
		logic [2:0]  saved_i;
		logic        int_inhibit;
		logic        kb_flag;
		logic [7:0]  kb_char;
		logic        pr_flag;
		logic        pr_full;
		logic        tty_ie;
		logic        tty_ir;
	} cpu_state_t;

	typedef struct packed {
		logic        re;
		logic [2:0]  field;
		logic [11:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic        we;
		logic [2:0]  field;
		logic [11:0] addr;
		logic [11:0] data;
	} mem_wr_t;

	function automatic logic [11:0] page_addr(logic [11:0] mbr, logic [11:0] mar);
		return (mbr[7] ? (mar & PAGE_MASK) : 12'd0) | (mbr & OFFSET_MASK);
	endfunction

	function automatic logic is_step(cpu_state_t s, item_t it);
		return (it.action == ACT_CYCLE && s.run_flag) ||
			((it.action == ACT_CONTINUE || it.action == ACT_START) &&
			!s.run_flag && it.single_step_switch);
	endfunction

	// the memory read an item needs, if any, decided from state and item alone
	function automatic mem_rd_t plan_read(cpu_state_t s, item_t it);
		mem_rd_t     r;
		logic        fetch;
		logic        irq;
		logic [11:0] pa;
		r = '0;
		fetch = 1'b1;
		irq = s.ion & s.tty_ie & (s.kb_flag | s.pr_flag) & ~s.int_inhibit;
		pa = page_addr(s.mbr, s.mar);
		if (it.action == ACT_LOAD_ADDR && !s.run_flag) begin
			r.re = 1'b1;
			r.field = it.inst_field_switch;
			r.addr = it.switch_register;
		end else if (it.action == ACT_EXAMINE && !s.run_flag) begin
			r.re = 1'b1;
			r.field = s.dfield;
			r.addr = s.pc;
		end else if (is_step(s, it)) begin
			case (s.cycle_state)
				ST_FETCH: begin
					if (!((s.mbr & JMP_MASK) == JMP_CODE || s.opcode_top >= OP_IOT)) begin
						fetch = 1'b0;
						if (s.mbr[8] || s.opcode_top <= OP_ISZ) begin
							r.re = 1'b1;
							r.field = s.ifield;
							r.addr = pa;
						end
					end
				end
				ST_DEFER: begin
					if (s.opcode_top != OP_JMP) begin
						fetch = 1'b0;
						if (s.opcode_top <= OP_ISZ) begin
							r.re = 1'b1;
							r.field = s.dfield;
							r.addr = s.mbr;
						end
					end
				end
				default: fetch = 1'b1;
			endcase
			if (fetch && !irq) begin
				r.re = 1'b1;
				r.field = s.ifield;
				r.addr = s.pc;
			end
		end
		return r;
	endfunction

endpackage

@@ hdl/mc12_if.sv @@
interface mc12_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic [11:0] switch_register;
	logic [2:0]  inst_field_switch;
	logic [2:0]  data_field_switch;
	logic        single_step_switch;
	logic [7:0]  key_char;
	modport source (output valid, action, switch_register, inst_field_switch,
		data_field_switch, single_step_switch, key_char, input ready);
	modport sink (input valid, action, switch_register, inst_field_switch,
		data_field_switch, single_step_switch, key_char, output ready);
endinterface

interface mc12_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  major_state;
	logic [11:0] program_counter;
	logic [11:0] accumulator;
	logic        link_bit;
	logic [11:0] memory_address;
	logic [11:0] memory_buffer;
	logic [2:0]  memory_field;
	logic [2:0]  instruction_field;
	logic        interrupt_on;
	logic        running;
	logic        print_valid;
	logic [7:0]  print_char;
	modport source (output valid, major_state, program_counter, accumulator, link_bit,
		memory_address, memory_buffer, memory_field, instruction_field, interrupt_on,
		running, print_valid, print_char, input ready);
	modport sink (input valid, major_state, program_counter, accumulator, link_bit,
		memory_address, memory_buffer, memory_field, instruction_field, interrupt_on,
		running, print_valid, print_char, output ready);
endinterface

interface mc12_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ hdl/mc12_ram.sv @@
module mc12_ram (
	input  logic             clk,
	input  logic             arst_n,
	input  mc12_pkg::mem_rd_t rd,
	input  mc12_pkg::mem_wr_t wr,
	input  logic [3:0]       fields_present,
	output logic [11:0]      rdata,
	output logic             clearing
);
	import mc12_pkg::*;

	localparam logic [MEM_AW:0] CLR_END = (MEM_AW + 1)'(MEM_DEPTH);

	logic [11:0]     mem [MEM_DEPTH];
	logic [MEM_AW:0] clr_q;
	logic            wr_ok;

	assign clearing = (clr_q != CLR_END);
	// absent fields drop writes
	assign wr_ok = wr.we && ({1'b0, wr.field} < fields_present) && (int'(wr.field) < MAX_FIELDS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem[clr_q[MEM_AW-1:0]] <= '0;
		end else if (wr_ok) begin
			mem[{wr.field, wr.addr}] <= wr.data;
		end
		if (rd.re) begin
			rdata <= mem[{rd.field, rd.addr}];
		end
	end

endmodule

@@ hdl/mc12_core.sv @@
module mc12_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  mc12_pkg::item_t      item,
	input  logic [11:0]          rdata,
	input  logic [2:0]           rfield,
	input  logic [3:0]           fields_present,
	output mc12_pkg::cpu_state_t st,
	output mc12_pkg::mem_wr_t    wr,
	output mc12_pkg::out_item_t  res
);
	import mc12_pkg::*;

	localparam logic [11:0] IOT_ION = 12'o6001;
	localparam logic [11:0] IOT_IOF = 12'o6002;
	localparam logic [11:0] IOT_KSF = 12'o6031;
	localparam logic [11:0] IOT_KCC = 12'o6032;
	localparam logic [11:0] IOT_KRS = 12'o6034;
	localparam logic [11:0] IOT_KIE = 12'o6035;
	localparam logic [11:0] IOT_KRB = 12'o6036;
	localparam logic [11:0] IOT_TSF = 12'o6041;
	localparam logic [11:0] IOT_TCF = 12'o6042;
	localparam logic [11:0] IOT_TPC = 12'o6044;
	localparam logic [11:0] IOT_TSK = 12'o6045;
	localparam logic [11:0] IOT_TLS = 12'o6046;
	localparam logic [11:0] IOT_RDF = 12'o6214;
	localparam logic [11:0] IOT_RIF = 12'o6224;
	localparam logic [11:0] IOT_RIB = 12'o6234;
	localparam logic [11:0] IOT_RMF = 12'o6244;
	localparam logic [11:0] CDF_MASK = 12'o7704;
	localparam logic [11:0] CDF_CODE = 12'o6200;

	cpu_state_t  st_q;
	cpu_state_t  n;
	mem_wr_t     w;
	logic [11:0] rd;
	logic [11:0] pa;
	logic [11:0] v;
	logic [12:0] sum;
	logic        do_step;
	logic        fetch_now;
	logic        memref_now;
	logic        skip;
	logic        irq_req;
	logic [2:0]  mr_f;
	logic [11:0] mr_a;
	logic        pv;
	logic [7:0]  pch;

	// absent fields read zero
	assign rd = ({1'b0, rfield} < fields_present && int'(rfield) < MAX_FIELDS) ? rdata : 12'd0;

	always_comb begin
		n = st_q;
		w = '0;
		pv = 1'b0;
		pch = '0;
		pa = '0;
		v = '0;
		sum = '0;
		skip = 1'b0;
		irq_req = 1'b0;
		fetch_now = 1'b0;
		memref_now = 1'b0;
		mr_f = '0;
		mr_a = '0;
		do_step = is_step(st_q, item);

		case (item.action)
			ACT_LOAD_ADDR: begin
				if (!st_q.run_flag) begin
					n.dfield = item.data_field_switch;
					n.ifield = item.inst_field_switch;
					n.ifa = item.inst_field_switch;
					n.pc = item.switch_register;
					n.access_field = item.inst_field_switch;
					n.mar = item.switch_register;
					n.mbr = rd;
					n.cycle_state = ST_NONE;
				end
			end
			ACT_DEPOSIT: begin
				if (!st_q.run_flag) begin
					w.we = 1'b1;
					w.field = st_q.dfield;
					w.addr = st_q.pc;
					w.data = item.switch_register;
					n.access_field = st_q.dfield;
					n.mar = st_q.pc;
					n.mbr = item.switch_register;
					n.pc = st_q.pc + 12'd1;
					n.cycle_state = ST_NONE;
				end
			end
			ACT_EXAMINE: begin
				if (!st_q.run_flag) begin
					n.access_field = st_q.dfield;
					n.mar = st_q.pc;
					n.mbr = rd;
					n.pc = st_q.pc + 12'd1;
					n.cycle_state = ST_NONE;
				end
			end
			ACT_CONTINUE: begin
				if (!st_q.run_flag && !item.single_step_switch) n.run_flag = 1'b1;
			end
			ACT_START: begin
				if (!st_q.run_flag) begin
					n.ac = '0;
					n.link = 1'b0;
					if (!item.single_step_switch) n.run_flag = 1'b1;
				end
			end
			ACT_KEY: begin
				n.kb_char = item.key_char;
				n.kb_flag = 1'b1;
			end
			ACT_PRINT_DONE: begin
				if (st_q.pr_full) begin
					n.pr_flag = 1'b1;
					n.pr_full = 1'b0;
				end
			end
			default: ;
		endcase

		// one major state
		if (do_step) begin
			case (st_q.cycle_state)
				ST_FETCH: begin
					if ((st_q.mbr & JMP_MASK) == JMP_CODE || st_q.opcode_top >= OP_IOT) begin
						fetch_now = 1'b1;
					end else begin
						pa = page_addr(st_q.mbr, st_q.mar);
						n.mar = pa;
						if (st_q.mbr[8]) begin
							n.cycle_state = ST_DEFER;
							n.access_field = st_q.ifield;
							n.mbr = rd;
							// auto-index locations
							if ((pa & AUTOINC_MASK) == AUTOINC_BASE) begin
								n.mbr = rd + 12'd1;
								w.we = 1'b1;
								w.field = st_q.ifield;
								w.addr = pa;
								w.data = rd + 12'd1;
							end
							if (st_q.opcode_top == OP_JMP) begin
								n.int_inhibit = 1'b0;
								n.ifield = st_q.ifa;
								n.pc = n.mbr;
							end
						end else begin
							memref_now = 1'b1;
							mr_f = st_q.ifield;
							mr_a = pa;
						end
					end
				end
				ST_DEFER: begin
					if (st_q.opcode_top == OP_JMP) begin
						fetch_now = 1'b1;
					end else begin
						memref_now = 1'b1;
						mr_f = st_q.dfield;
						mr_a = st_q.mbr;
					end
				end
				default: fetch_now = 1'b1;
			endcase
		end

		if (memref_now) begin
			n.cycle_state = ST_EXEC;
			n.access_field = mr_f;
			n.mar = mr_a;
			case (st_q.opcode_top)
				OP_AND: begin
					n.mbr = rd;
					n.ac = n.ac & rd;
				end
				OP_TAD: begin
					n.mbr = rd;
					sum = {1'b0, n.ac} + {1'b0, rd};
					n.link = n.link ^ sum[12];
					n.ac = sum[11:0];
				end
				OP_ISZ: begin
					v = rd + 12'd1;
					n.mbr = v;
					w.we = 1'b1;
					w.field = mr_f;
					w.addr = mr_a;
					w.data = v;
					if (v == 12'd0) n.pc = n.pc + 12'd1;
				end
				OP_DCA: begin
					n.mbr = n.ac;
					w.we = 1'b1;
					w.field = mr_f;
					w.addr = mr_a;
					w.data = n.ac;
					n.ac = '0;
				end
				OP_JMS: begin
					n.int_inhibit = 1'b0;
					n.ifield = st_q.ifa;
					n.access_field = st_q.ifa;
					n.mbr = n.pc;
					w.we = 1'b1;
					w.field = st_q.ifa;
					w.addr = mr_a;
					w.data = n.pc;
					n.pc = mr_a + 12'd1;
				end
				default: ;
			endcase
		end

		if (fetch_now) begin
			irq_req = st_q.tty_ie & (st_q.kb_flag | st_q.pr_flag);
			n.tty_ir = irq_req;
			if (st_q.ion && irq_req && !st_q.int_inhibit) begin
				// interrupt: save pc at field 0 location 0
				n.saved_d = st_q.dfield;
				n.saved_i = st_q.ifield;
				n.dfield = '0;
				n.ifield = '0;
				n.ifa = '0;
				n.ion_delay = 1'b0;
				n.ion = 1'b0;
				n.cycle_state = ST_EXEC;
				n.access_field = '0;
				n.mar = '0;
				n.mbr = n.pc;
				w.we = 1'b1;
				w.field = '0;
				w.addr = '0;
				w.data = n.pc;
				n.pc = 12'd1;
			end else begin
				n.ion = st_q.ion_delay;
				n.cycle_state = ST_FETCH;
				n.access_field = st_q.ifield;
				n.mar = st_q.pc;
				n.mbr = rd;
				n.opcode_top = rd[11:9];
				n.pc = st_q.pc + 12'd1;
				if (rd[11:10] == 2'b10) n.int_inhibit = 1'b0;
				if ((rd & JMP_MASK) == JMP_CODE) begin
					n.int_inhibit = 1'b0;
					n.ifield = st_q.ifa;
					n.pc = page_addr(rd, st_q.pc);
				end else if (rd[11:9] == OP_IOT) begin
					if ((rd & CDF_MASK) == CDF_CODE && rd[1:0] != 2'b00) begin
						if (rd[0]) n.dfield = rd[5:3];
						if (rd[1]) begin
							n.ifa = rd[5:3];
							n.int_inhibit = 1'b1;
						end
					end else begin
						case (rd)
							IOT_ION: n.ion_delay = 1'b1;
							IOT_IOF: begin
								n.ion_delay = 1'b0;
								n.ion = 1'b0;
							end
							IOT_KSF: if (n.kb_flag) n.pc = n.pc + 12'd1;
							IOT_KCC: begin
								n.ac = '0;
								n.kb_flag = 1'b0;
							end
							IOT_KRS: n.ac = n.ac | {4'd0, n.kb_char};
							IOT_KIE: n.tty_ie = n.ac[0];
							IOT_KRB: begin
								n.ac = {4'd0, n.kb_char};
								n.kb_flag = 1'b0;
							end
							IOT_TSF: if (n.pr_flag) n.pc = n.pc + 12'd1;
							IOT_TCF: n.pr_flag = 1'b0;
							IOT_TPC: begin
								pv = 1'b1;
								pch = n.ac[7:0];
								n.pr_full = 1'b1;
							end
							IOT_TSK: if (n.tty_ir) n.pc = n.pc + 12'd1;
							IOT_TLS: begin
								pv = 1'b1;
								pch = n.ac[7:0];
								n.pr_flag = 1'b0;
								n.pr_full = 1'b1;
							end
							IOT_RDF: n.ac = n.ac | {6'd0, n.dfield, 3'd0};
							IOT_RIF: n.ac = n.ac | {6'd0, n.ifield, 3'd0};
							IOT_RIB: n.ac = n.ac | {6'd0, n.saved_i, n.saved_d};
							IOT_RMF: begin
								n.dfield = n.saved_d;
								n.ifa = n.saved_i;
							end
							default: ;
						endcase
					end
				end else if (rd[11:9] == OP_OPR) begin
					if (!rd[8]) begin
						// group 1
						if (rd[7]) n.ac = '0;
						if (rd[6]) n.link = 1'b0;
						if (rd[5]) n.ac = ~n.ac;
						if (rd[4]) n.link = ~n.link;
						if (rd[0]) begin
							sum = {1'b0, n.ac} + 13'd1;
							n.link = n.link ^ sum[12];
							n.ac = sum[11:0];
						end
						// code one swaps the halves, codes two to five rotate through the link, codes six and seven do nothing
						case (rd[3:1])
							3'd1: n.ac = {n.ac[5:0], n.ac[11:6]};
							3'd2: {n.link, n.ac} = {n.ac, n.link};
							3'd3: {n.link, n.ac} = {n.ac[10:0], n.link, n.ac[11]};
							3'd4: {n.ac, n.link} = {n.link, n.ac};
							3'd5: {n.link, n.ac} = {n.ac[1:0], n.link, n.ac[11:2]};
							default: ;
						endcase
					end else if (!rd[0]) begin
						// group 2
						skip = (rd[6] & n.ac[11]) | (rd[5] & (n.ac == 12'd0)) |
							(rd[4] & n.link);
						if (rd[3]) skip = !skip;
						if (skip) n.pc = n.pc + 12'd1;
						if (rd[7]) n.ac = '0;
						if (rd[1]) n.run_flag = 1'b0;
						if (rd[2]) n.ac = n.ac | item.switch_register;
					end
				end
			end
		end

		if (item.action inside {[ACT_LOAD_ADDR:ACT_STOP]} &&
			(item.action == ACT_STOP || item.single_step_switch)) begin
			n.run_flag = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			st_q.tty_ie <= 1'b1;
		end else if (go) begin
			st_q <= n;
		end
	end

	assign st = st_q;
	assign wr = w;

	always_comb begin
		res.major_state = n.cycle_state;
		res.program_counter = n.pc;
		res.accumulator = n.ac;
		res.link_bit = n.link;
		res.memory_address = n.mar;
		res.memory_buffer = n.mbr;
		res.memory_field = n.access_field;
		res.instruction_field = n.ifield;
		res.interrupt_on = n.ion;
		res.running = n.run_flag;
		res.print_valid = pv;
		res.print_char = pch;
	end

endmodule

@@ hdl/minicomputer_12bit_cpu_core_top.sv @@
// channel   | dir | handshake          | carries
// item_in   | in  | valid/ready        | panel action, switches, key char
// item_out  | out | valid/ready        | processor registers after the item
// cfg       | in  | valid/ready        | fields_present, 4 bits
//
// at the accept edge an item issues the memory read it needs, if any;
// at the completion edge it commits state, its memory write and the result
// completion waits while the result register is full and not being emptied
// after reset all 32768 memory words are cleared, with item_in.ready low
// a full result register whose item is not taken holds the item in flight
`include "minicomputer_12bit_cpu_core_top_defines.svh"
module minicomputer_12bit_cpu_core_top (
	input logic          clk,
	input logic          arst_n,
	mc12_in_if.sink      item_in,
	mc12_out_if.source   item_out,
	mc12_cfg_if.sink     cfg
);
	import mc12_pkg::*;

	item_t      item_w;
	item_t      item_s1;
	logic       busy_s1;
	logic [2:0] rfield_s1;
	out_item_t  out_q;
	out_item_t  res;
	logic       out_valid_q;
	logic [3:0] fields_q;
	cpu_state_t st;
	mem_rd_t    plan;
	mem_rd_t    ram_rd;
	mem_wr_t    core_wr;
	mem_wr_t    ram_wr;
	logic [11:0] rdata;
	logic       clearing;
	logic       accept;
	logic       complete;

	// input item as one struct
	assign item_w.action = item_in.action;
	assign item_w.switch_register = item_in.switch_register;
	assign item_w.inst_field_switch = item_in.inst_field_switch;
	assign item_w.data_field_switch = item_in.data_field_switch;
	assign item_w.single_step_switch = item_in.single_step_switch;
	assign item_w.key_char = item_in.key_char;

	assign item_in.ready = !busy_s1 && !clearing;
	assign accept = item_in.valid && item_in.ready;
	// finish when the result register is free or being emptied
	assign complete = busy_s1 && (!out_valid_q || item_out.ready);

	// read issued at accept, state is stable until completion
	assign plan = plan_read(st, item_w);
	always_comb begin
		ram_rd = plan;
		ram_rd.re = plan.re && accept;
		ram_wr = core_wr;
		ram_wr.we = core_wr.we && complete;
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			fields_q <= 4'd2;
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (complete) begin
				busy_s1 <= 1'b0;
			end
			if (complete) begin
				out_valid_q <= 1'b1;
			end else if (item_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				fields_q <= cfg.data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_w;
			rfield_s1 <= plan.field;
		end
		if (complete) begin
			out_q <= res;
		end
	end

	mc12_ram u_ram (
		.clk            (clk),
		.arst_n         (arst_n),
		.rd             (ram_rd),
		.wr             (ram_wr),
		.fields_present (fields_q),
		.rdata          (rdata),
		.clearing       (clearing)
	);

	mc12_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (complete),
		.item           (item_s1),
		.rdata          (rdata),
		.rfield         (rfield_s1),
		.fields_present (fields_q),
		.st             (st),
		.wr             (core_wr),
		.res            (res)
	);

	assign item_out.valid = out_valid_q;
	assign item_out.major_state = out_q.major_state;
	assign item_out.program_counter = out_q.program_counter;
	assign item_out.accumulator = out_q.accumulator;
	assign item_out.link_bit = out_q.link_bit;
	assign item_out.memory_address = out_q.memory_address;
	assign item_out.memory_buffer = out_q.memory_buffer;
	assign item_out.memory_field = out_q.memory_field;
	assign item_out.instruction_field = out_q.instruction_field;
	assign item_out.interrupt_on = out_q.interrupt_on;
	assign item_out.running = out_q.running;
	assign item_out.print_valid = out_q.print_valid;
	assign item_out.print_char = out_q.print_char;

	`MC12_ASSERT_NEXT(a_accept_in_flight, accept, busy_s1)
	`MC12_ASSERT_NEXT(a_stall_holds_item, busy_s1 && !complete, busy_s1 && $stable(item_s1))
	`MC12_ASSERT_NEXT(a_complete_shows_result, complete, out_valid_q)
	`MC12_ASSERT_IMPL(a_write_in_flight, ram_wr.we, busy_s1 && !clearing)

endmodule

@@ tb/mc12_checker.sv @@
module mc12_checker
	import mc12_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	mc12_in_if   in_c,
	mc12_out_if  out_c,
	mc12_cfg_if  cfg_c,
	output int   fail_count,
	output int   pending
);

	localparam logic [11:0] IOT_ION  = 12'o6001;
	localparam logic [11:0] IOT_IOF  = 12'o6002;
	localparam logic [11:0] IOT_KSF  = 12'o6031;
	localparam logic [11:0] IOT_KCC  = 12'o6032;
	localparam logic [11:0] IOT_KRS  = 12'o6034;
	localparam logic [11:0] IOT_KIE  = 12'o6035;
	localparam logic [11:0] IOT_KRB  = 12'o6036;
	localparam logic [11:0] IOT_TSF  = 12'o6041;
	localparam logic [11:0] IOT_TCF  = 12'o6042;
	localparam logic [11:0] IOT_TPC  = 12'o6044;
	localparam logic [11:0] IOT_TSK  = 12'o6045;
	localparam logic [11:0] IOT_TLS  = 12'o6046;
	localparam logic [11:0] IOT_RDF  = 12'o6214;
	localparam logic [11:0] IOT_RIF  = 12'o6224;
	localparam logic [11:0] IOT_RIB  = 12'o6234;
	localparam logic [11:0] IOT_RMF  = 12'o6244;

	logic [11:0] core [MEM_DEPTH];
	logic [3:0]  fields;
	logic [11:0] pc, ac, mar, mbr;
	logic        lnk;
	logic [2:0]  acc_f, op_top, ifield, dfield, if_jump, sav_d, sav_i;
	major_t      cstate;
	logic        ion, ion_dly, run, inhibit;
	logic        kb_flag, pr_flag, pr_full, tty_ie, tty_ir;
	logic [7:0]  kb_char, pchar;
	logic        pvalid;
	logic [11:0] sw;

	out_item_t   panel_q[$];
	int          mism;

	assign pending = panel_q.size();

	task automatic mread(input logic [2:0] f, input logic [11:0] a);
		acc_f = f;
		mar = a;
		mbr = '0;
		if (f < fields) mbr = core[{f, a}];
	endtask

	task automatic mwrite(input logic [2:0] f, input logic [11:0] a, input logic [11:0] d);
		acc_f = f;
		mar = a;
		mbr = d;
		if (f < fields) core[{f, a}] = d;
	endtask

	function automatic logic [11:0] eff_addr();
		return (mbr[7] ? (mar & PAGE_MASK) : 12'd0) | (mbr & OFFSET_MASK);
	endfunction

	task automatic operate();
		logic [12:0] t;
		logic        skip;
		if (!mbr[8]) begin
			if (mbr[7]) ac = '0;
			if (mbr[6]) lnk = 1'b0;
			if (mbr[5]) ac = ~ac;
			if (mbr[4]) lnk = ~lnk;
			if (mbr[0]) begin
				t = {1'b0, ac} + 13'd1;
				lnk ^= t[12];
				ac = t[11:0];
			end
			case (mbr[3:1])
				3'd1: ac = {ac[5:0], ac[11:6]};
				3'd2: {lnk, ac} = {ac, lnk};
				3'd3: {lnk, ac} = {ac[10:0], lnk, ac[11]};
				3'd4: {ac, lnk} = {lnk, ac};
				3'd5: {lnk, ac} = {ac[1:0], lnk, ac[11:2]};
				default: ;
			endcase
		end else if (!mbr[0]) begin
			skip = 1'b0;
			if (mbr[6] && ac[11]) skip = 1'b1;
			if (mbr[5] && ac == 0) skip = 1'b1;
			if (mbr[4] && lnk) skip = 1'b1;
			if (mbr[3]) skip = !skip;
			if (skip) pc = pc + 12'd1;
			if (mbr[7]) ac = '0;
			if (mbr[1]) run = 1'b0;
		end
	endtask

	task automatic iot();
		if ((mbr & 12'o7704) == 12'o6200 && mbr[1:0] != 0) begin
			if (mbr[0]) dfield = mbr[5:3];
			if (mbr[1]) begin
				if_jump = mbr[5:3];
				inhibit = 1'b1;
			end
			return;
		end
		case (mbr)
			IOT_ION: ion_dly = 1'b1;
			IOT_IOF: begin
				ion_dly = 1'b0;
				ion = 1'b0;
			end
			IOT_KSF: if (kb_flag) pc = pc + 12'd1;
			IOT_KCC: begin
				ac = '0;
				kb_flag = 1'b0;
			end
			IOT_KRS: ac |= {4'd0, kb_char};
			IOT_KIE: tty_ie = ac[0];
			IOT_KRB: begin
				ac = {4'd0, kb_char};
				kb_flag = 1'b0;
			end
			IOT_TSF: if (pr_flag) pc = pc + 12'd1;
			IOT_TCF: pr_flag = 1'b0;
			IOT_TPC: begin
				pvalid = 1'b1;
				pchar = ac[7:0];
				pr_full = 1'b1;
			end
			IOT_TSK: if (tty_ir) pc = pc + 12'd1;
			IOT_TLS: begin
				pvalid = 1'b1;
				pchar = ac[7:0];
				pr_flag = 1'b0;
				pr_full = 1'b1;
			end
			IOT_RDF: ac |= {6'd0, dfield, 3'd0};
			IOT_RIF: ac |= {6'd0, ifield, 3'd0};
			IOT_RIB: ac |= {6'd0, sav_i, sav_d};
			IOT_RMF: begin
				dfield = sav_d;
				if_jump = sav_i;
			end
			default: ;
		endcase
	endtask

	task automatic fetch();
		tty_ir = tty_ie & (kb_flag | pr_flag);
		if (ion && tty_ir && !inhibit) begin
			// interrupt: save fields, store pc at 0 and resume at 1
			sav_d = dfield;
			sav_i = ifield;
			dfield = '0;
			ifield = '0;
			if_jump = '0;
			ion_dly = 1'b0;
			ion = 1'b0;
			cstate = ST_EXEC;
			mwrite(3'd0, 12'd0, pc);
			pc = 12'd1;
			return;
		end
		ion = ion_dly;
		cstate = ST_FETCH;
		mread(ifield, pc);
		op_top = mbr[11:9];
		pc = pc + 12'd1;
		if (op_top[2:1] == 2'b10) inhibit = 1'b0;
		if ((mbr & JMP_MASK) == JMP_CODE) begin
			inhibit = 1'b0;
			ifield = if_jump;
			pc = eff_addr();
		end else if (op_top == OP_IOT) begin
			iot();
		end else if (op_top == OP_OPR) begin
			operate();
			if (mbr[8] && !mbr[0] && mbr[2]) ac |= sw;
		end
	endtask

	task automatic memref(input logic [2:0] f);
		logic [11:0] a;
		logic [12:0] t;
		a = mar;
		cstate = ST_EXEC;
		case (op_top)
			OP_AND: begin
				mread(f, a);
				ac &= mbr;
			end
			OP_TAD: begin
				mread(f, a);
				t = {1'b0, ac} + {1'b0, mbr};
				lnk ^= t[12];
				ac = t[11:0];
			end
			OP_ISZ: begin
				mread(f, a);
				mwrite(f, a, mbr + 12'd1);
				if (mbr == 0) pc = pc + 12'd1;
			end
			OP_DCA: begin
				mwrite(f, a, ac);
				ac = '0;
			end
			OP_JMS: begin
				inhibit = 1'b0;
				ifield = if_jump;
				mwrite(ifield, a, pc);
				pc = a + 12'd1;
			end
			default: ;
		endcase
	endtask

	task automatic advance();
		case (cstate)
			ST_FETCH: begin
				if ((mbr & JMP_MASK) == JMP_CODE || op_top >= OP_IOT) begin
					fetch();
				end else begin
					mar = eff_addr();
					if (mbr[8]) begin
						cstate = ST_DEFER;
						mread(ifield, mar);
						// auto-index locations
						if ((mar & AUTOINC_MASK) == AUTOINC_BASE)
							mwrite(ifield, mar, mbr + 12'd1);
						if (op_top == OP_JMP) begin
							inhibit = 1'b0;
							ifield = if_jump;
							pc = mbr;
						end
					end else begin
						acc_f = ifield;
						memref(ifield);
					end
				end
			end
			ST_DEFER: begin
				if (op_top == OP_JMP) begin
					fetch();
				end else begin
					acc_f = dfield;
					mar = mbr;
					memref(dfield);
				end
			end
			default: fetch();
		endcase
	endtask

	task automatic panel_continue(input logic stp);
		if (stp) advance();
		else run = 1'b1;
	endtask

	task automatic apply_item(input item_t it);
		out_item_t r;
		pvalid = 1'b0;
		pchar = '0;
		sw = it.switch_register;
		if (it.action == ACT_CYCLE) begin
			if (run) advance();
		end else if (it.action <= ACT_STOP) begin
			if (!run) begin
				case (it.action)
					ACT_LOAD_ADDR: begin
						dfield = it.data_field_switch;
						ifield = it.inst_field_switch;
						if_jump = it.inst_field_switch;
						pc = it.switch_register;
						mread(ifield, pc);
						cstate = ST_NONE;
					end
					ACT_DEPOSIT: begin
						mwrite(dfield, pc, it.switch_register);
						pc = pc + 12'd1;
						cstate = ST_NONE;
					end
					ACT_EXAMINE: begin
						mread(dfield, pc);
						pc = mar + 12'd1;
						cstate = ST_NONE;
					end
					ACT_CONTINUE: panel_continue(it.single_step_switch);
					ACT_START: begin
						ac = '0;
						lnk = 1'b0;
						panel_continue(it.single_step_switch);
					end
					default: ;
				endcase
			end
			if (it.action == ACT_STOP || it.single_step_switch) run = 1'b0;
		end else if (it.action == ACT_KEY) begin
			kb_char = it.key_char;
			kb_flag = 1'b1;
		end else if (it.action == ACT_PRINT_DONE) begin
			if (pr_full) begin
				pr_flag = 1'b1;
				pr_full = 1'b0;
			end
		end
		r.major_state = cstate;
		r.program_counter = pc;
		r.accumulator = ac;
		r.link_bit = lnk;
		r.memory_address = mar;
		r.memory_buffer = mbr;
		r.memory_field = acc_f;
		r.instruction_field = ifield;
		r.interrupt_on = ion;
		r.running = run;
		r.print_valid = pvalid;
		r.print_char = pchar;
		panel_q.push_back(r);
	endtask

	task automatic clear_state();
		foreach (core[i]) core[i] = '0;
		fields = 4'd2;
		pc = '0; ac = '0; lnk = 0; mar = '0; mbr = '0;
		acc_f = '0; op_top = '0; cstate = ST_NONE;
		ion = 0; ion_dly = 0; run = 0;
		ifield = '0; dfield = '0; if_jump = '0; sav_d = '0; sav_i = '0;
		inhibit = 0; kb_flag = 0; kb_char = '0; pr_flag = 0; pr_full = 0;
		tty_ie = 1; tty_ir = 0;
		panel_q.delete();
	endtask

	initial begin
		fail_count = 0;
		mism = 0;
		clear_state();
	end

	always @(posedge clk or negedge arst_n) begin
		item_t     it;
		out_item_t got, want;
		if (!arst_n) begin
			clear_state();
		end else begin
			if (cfg_c.valid && cfg_c.ready) fields = cfg_c.data;
			if (in_c.valid && in_c.ready) begin
				it.action = in_c.action;
				it.switch_register = in_c.switch_register;
				it.inst_field_switch = in_c.inst_field_switch;
				it.data_field_switch = in_c.data_field_switch;
				it.single_step_switch = in_c.single_step_switch;
				it.key_char = in_c.key_char;
				apply_item(it);
			end
			if (out_c.valid && out_c.ready) begin
				got.major_state = out_c.major_state;
				got.program_counter = out_c.program_counter;
				got.accumulator = out_c.accumulator;
				got.link_bit = out_c.link_bit;
				got.memory_address = out_c.memory_address;
				got.memory_buffer = out_c.memory_buffer;
				got.memory_field = out_c.memory_field;
				got.instruction_field = out_c.instruction_field;
				got.interrupt_on = out_c.interrupt_on;
				got.running = out_c.running;
				got.print_valid = out_c.print_valid;
				got.print_char = out_c.print_char;
				if (panel_q.size() == 0) begin
					fail_count++;
					mism++;
					if (mism <= 10) $display("unexpected result item %p", got);
				end else begin
					want = panel_q.pop_front();
					if (got !== want) begin
						fail_count++;
						mism++;
						if (mism <= 10)
							$display("mismatch at %0t\n  expected %p\n  actual   %p",
								$realtime, want, got);
					end
				end
			end
		end
	end

endmodule

@@ tb/tb.sv @@
module tb;
	import mc12_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;

	mc12_in_if  in_if();
	mc12_out_if out_if();
	mc12_cfg_if cfg_if();

	minicomputer_12bit_cpu_core_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (in_if),
		.item_out (out_if),
		.cfg      (cfg_if)
	);

	// predicts every result item and counts failures
	mc12_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_c       (in_if),
		.out_c      (out_if),
		.cfg_c      (cfg_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// idle and stall percentages for the current phase
	int send_idle;
	int recv_stall;
	// long receiver hold-off, requested by the stimulus, counted below
	int hold_req;
	int hold_left;
	int sent;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// receiver side: random stalls, plus the long hold-off
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_if.ready = 1'b0;
			hold_left--;
		end else begin
			out_if.ready = ($urandom_range(99) >= recv_stall);
		end
	end

	// generous cap: clearing pass plus the slowest stalls several times over
	initial begin
		#24_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic item_t mk(logic [3:0] act, logic [11:0] sr, logic [2:0] ifs,
		logic [2:0] dfs, logic stp, logic [7:0] key);
		item_t it;
		it.action = act;
		it.switch_register = sr;
		it.inst_field_switch = ifs;
		it.data_field_switch = dfs;
		it.single_step_switch = stp;
		it.key_char = key;
		return it;
	endfunction

	// one item onto the input channel; valid stays high into the next item
	task automatic send(input item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_if.valid = 1'b0;
			@(negedge clk);
		end
		in_if.action = it.action;
		in_if.switch_register = it.switch_register;
		in_if.inst_field_switch = it.inst_field_switch;
		in_if.data_field_switch = it.data_field_switch;
		in_if.single_step_switch = it.single_step_switch;
		in_if.key_char = it.key_char;
		in_if.valid = 1'b1;
		do @(posedge clk); while (!in_if.ready);
		@(negedge clk);
		sent++;
	endtask

	// register write only with nothing in flight
	task automatic set_fields(input logic [3:0] n);
		in_if.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_if.data = n;
		cfg_if.valid = 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// instruction mix: memory reference, operate, known device codes, jumps, noise
	function automatic logic [11:0] rand_instr();
		logic [5:0] dev [5] = '{6'o00, 6'o03, 6'o04, 6'o20, 6'o21};
		int         r;
		r = $urandom_range(9);
		if (r <= 4) return {3'($urandom_range(4)), 9'($urandom)};
		if (r <= 6) return {OP_OPR, 9'($urandom)};
		if (r == 7) begin
			if ($urandom_range(3) == 0)
				return {OP_IOT, 3'o2, 3'($urandom), 1'b0, 2'($urandom_range(1, 3))};
			return {OP_IOT, dev[$urandom_range(4)], 3'($urandom)};
		end
		if (r == 8) return {OP_JMP, 1'($urandom), 1'b1, 7'($urandom)};
		return 12'($urandom);
	endfunction

	function automatic item_t rand_item();
		return mk(4'($urandom_range(8)), 12'($urandom), 3'($urandom), 3'($urandom),
			1'($urandom), 8'($urandom));
	endfunction

	// load a short program somewhere, then run it freely or by single steps
	task automatic run_program();
		logic [2:0]  f;
		logic [11:0] base;
		int          n;
		logic        stepping;
		f = 3'($urandom);
		if ($urandom_range(2) != 0) f = 3'($urandom_range(1));
		base = 12'($urandom);
		if ($urandom_range(3) == 0) base = 12'o0010;
		send(mk(ACT_STOP, '0, '0, '0, 1'b0, '0));
		send(mk(ACT_LOAD_ADDR, base, f, f, 1'b0, '0));
		n = $urandom_range(4, 12);
		repeat (n) send(mk(ACT_DEPOSIT, rand_instr(), '0, '0, 1'b0, '0));
		send(mk(ACT_LOAD_ADDR, base, f, 3'($urandom), 1'b0, '0));
		stepping = ($urandom_range(3) == 0);
		if (stepping) begin
			repeat ($urandom_range(5, 20))
				send(mk($urandom_range(1) ? ACT_CONTINUE : ACT_START, 12'($urandom),
					'0, '0, 1'b1, '0));
		end else begin
			send(mk(ACT_START, 12'($urandom), '0, '0, 1'b0, '0));
			repeat ($urandom_range(10, 40)) begin
				case ($urandom_range(19))
					0, 1: send(mk(ACT_KEY, '0, '0, '0, 1'b0, 8'($urandom)));
					2, 3: send(mk(ACT_PRINT_DONE, '0, '0, '0, 1'b0, '0));
					4: send(rand_item());
					default: send(mk(ACT_CYCLE, 12'($urandom), '0, '0, 1'b0, '0));
				endcase
			end
		end
	endtask

	initial begin
		int          send_pct [4] = '{0, 79, 0, 37};
		int          recv_pct [4] = '{0, 0, 79, 37};
		logic [3:0]  fld_val  [5] = '{4'd8, 4'd1, 4'd2, 4'd8, 4'd5};
		item_t       dir [$];
		int          target;

		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.action = ACT_CYCLE;
		in_if.switch_register = '0;
		in_if.inst_field_switch = '0;
		in_if.data_field_switch = '0;
		in_if.single_step_switch = 1'b0;
		in_if.key_char = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		out_if.ready = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		hold_req = 0;
		hold_left = 0;
		sent = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: default field count, switch extremes, every action
		dir.push_back(mk(ACT_CYCLE, 12'o7777, 3'd7, 3'd7, 1'b0, 8'hff));
		dir.push_back(mk(ACT_LOAD_ADDR, 12'o7777, 3'd7, 3'd7, 1'b0, 8'h00));
		dir.push_back(mk(ACT_DEPOSIT, 12'o7777, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_EXAMINE, 12'o0000, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_LOAD_ADDR, 12'o0200, 3'd1, 3'd1, 1'b0, 8'h00));
		dir.push_back(mk(ACT_DEPOSIT, 12'o6001, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_DEPOSIT, 12'o1377, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_DEPOSIT, 12'o6046, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_DEPOSIT, 12'o7404, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_DEPOSIT, 12'o5201, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_LOAD_ADDR, 12'o0200, 3'd1, 3'd1, 1'b0, 8'h00));
		// one major state per step switch press
		dir.push_back(mk(ACT_START, 12'o0000, 3'd0, 3'd0, 1'b1, 8'h00));
		dir.push_back(mk(ACT_CONTINUE, 12'o7777, 3'd0, 3'd0, 1'b1, 8'h00));
		// run freely, panel ignored while running
		dir.push_back(mk(ACT_CONTINUE, 12'o0000, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_CYCLE, 12'o5252, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_DEPOSIT, 12'o1234, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_CYCLE, 12'o7777, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_PRINT_DONE, 12'o0000, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_KEY, 12'o0000, 3'd0, 3'd0, 1'b0, 8'hff));
		dir.push_back(mk(ACT_CYCLE, 12'o0000, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_CYCLE, 12'o0000, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_STOP, 12'o0000, 3'd0, 3'd0, 1'b0, 8'h00));
		// printer done with nothing pending, cycle while stopped
		dir.push_back(mk(ACT_PRINT_DONE, 12'o0000, 3'd0, 3'd0, 1'b0, 8'h00));
		dir.push_back(mk(ACT_CYCLE, 12'o0000, 3'd0, 3'd0, 1'b0, 8'h00));
		foreach (dir[i]) send(dir[i]);

		for (int p = 0; p < 5; p++) begin
			set_fields(fld_val[p]);
			send_idle = send_pct[p % 4];
			recv_stall = recv_pct[p % 4];
			// fill the block up against a stalled output once
			if (p == 0) hold_req = 400;
			target = sent + 380;
			while (sent < target) begin
				if ($urandom_range(9) == 0) send(rand_item());
				else run_program();
			end
		end

		in_if.valid = 1'b0;
		recv_stall = 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
